// ----- hw/rtl/vdv_pkg.sv -----
// ----------------------------------------------------------------------------
// vdv_pkg
// Shared types and constants for the VRML delimiter validator: verdict codes,
// the fixed header text, the keyword table and the closer stack interface.
// ----------------------------------------------------------------------------
package vdv_pkg;

  localparam int DEF_MAX_NESTING = 1024;

  localparam int HDR_LEN  = 15;
  localparam int WIN_LEN  = 14;
  localparam int KW_COUNT = 6;

  typedef enum logic [2:0] {
    VERDICT_OK       = 3'd0,
    VERDICT_HEADER   = 3'd1,
    VERDICT_DEPTH    = 3'd2,
    VERDICT_MISMATCH = 3'd3,
    VERDICT_CONTROL  = 3'd4,
    VERDICT_FINAL    = 3'd5
  } verdict_t;

  localparam logic [8*HDR_LEN-1:0] HDR_TEXT = "#VRML V2.0 utf8";

  // Keywords are right-aligned in a window-wide vector; the newest byte is
  // the low byte. Bits 0 and 1 are required, bits 2 to 5 are forbidden.
  localparam logic [8*WIN_LEN-1:0] KW_TEXT [KW_COUNT] = '{
    "Transform {",
    "IndexedFaceSet",
    "Script {",
    "Inline {",
    "Anchor {",
    "EXTERNPROTO"
  };
  localparam int KW_LEN [KW_COUNT] = '{11, 14, 8, 8, 8, 11};

  localparam logic [KW_COUNT-1:0] KW_REQUIRED  = 6'b000011;
  localparam logic [KW_COUNT-1:0] KW_FORBIDDEN = 6'b111100;

  // Stack command for one byte: at most one of push and pop is set.
  typedef struct packed {
    logic push;
    logic pop;
    logic bracket;   // pushed closer: 1 for ']', 0 for '}'
    logic clear;     // end of file, level returns to zero
  } stk_cmd_t;

  typedef struct packed {
    logic empty;
    logic one_left;
    logic full;
    logic top_bracket;
  } stk_status_t;

  function automatic logic [7:0] hdr_byte(input logic [3:0] pos);
    int idx;
    idx = HDR_LEN - 1 - int'(pos);
    if (int'(pos) < HDR_LEN) begin
      return HDR_TEXT[8*idx +: 8];
    end
    return 8'h00;
  endfunction

endpackage

// ----- hw/rtl/vdv_kw_match.sv -----
// ----------------------------------------------------------------------------
// vdv_kw_match
// Compares the byte window that ends at the current byte against each
// keyword and flags every keyword that ends here.
// ----------------------------------------------------------------------------
module vdv_kw_match import vdv_pkg::*; (
  input  logic [8*WIN_LEN-1:0] win,
  output logic [KW_COUNT-1:0]  hits
);

  for (genvar k = 0; k < KW_COUNT; k++) begin : g_kw
    localparam int L = KW_LEN[k];
    localparam logic [8*WIN_LEN-1:0] MASK = (8*WIN_LEN)'({(8*L){1'b1}});
    assign hits[k] = ((win & MASK) == KW_TEXT[k]);
  end

endmodule

// ----- hw/rtl/vdv_stack.sv -----
// ----------------------------------------------------------------------------
// vdv_stack
// Closer stack: one bit per open delimiter in a memory, with the level in a
// register. The top entry is read every cycle at the address below the next level,
// so it is ready for the following byte.
// ----------------------------------------------------------------------------
module vdv_stack import vdv_pkg::*; #(
  parameter int MAX_NESTING = DEF_MAX_NESTING
) (
  input  logic        clk,
  input  logic        rst,
  input  stk_cmd_t    cmd,
  output stk_status_t status
);

  localparam int LW = $clog2(MAX_NESTING + 1);
  localparam int AW = (MAX_NESTING > 1) ? $clog2(MAX_NESTING) : 1;

  logic          mem [MAX_NESTING];
  logic [LW-1:0] level;
  logic [LW-1:0] level_next;
  logic [LW-1:0] top_index;
  logic          rd_bit;
  logic          byp;
  logic          byp_bit;

  always_comb begin
    if (cmd.clear) begin
      level_next = '0;
    end else if (cmd.push) begin
      level_next = level + LW'(1);
    end else if (cmd.pop) begin
      level_next = level - LW'(1);
    end else begin
      level_next = level;
    end
    top_index = level_next - LW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level <= '0;
      byp   <= 1'b0;
    end else begin
      level <= level_next;
      // A push writes exactly the entry that becomes the new top.
      byp   <= cmd.push && !cmd.clear;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[level[AW-1:0]] <= cmd.bracket;
    end
    rd_bit  <= mem[top_index[AW-1:0]];
    byp_bit <= cmd.bracket;
  end

  assign status.empty       = (level == '0);
  assign status.one_left    = (level == LW'(1));
  assign status.full        = (level == LW'(MAX_NESTING));
  assign status.top_bracket = byp ? byp_bit : rd_bit;

endmodule

// ----- hw/rtl/vrml_delimiter_validator_top.sv -----
// verdict_valid is set by a register when the last file byte leaves the input register.
// Throughput: one byte per cycle, set by the input register and the
// scan step with a one-read, one-write stack memory.
// A verdict that waits in the output register stalls only the next last byte.
// Reset (rst, synchronous) returns every scan state to its start value; the
// stack memory is never cleared since only entries below the level are read.
// ----------------------------------------------------------------------------
// vrml_delimiter_validator_top
// Checks a VRML text file byte by byte: header, NUL bytes, comments, strings,
// delimiter nesting, control characters and keywords; one verdict per file.
// ----------------------------------------------------------------------------
module vrml_delimiter_validator_top import vdv_pkg::*; #(
  parameter int MAX_NESTING = DEF_MAX_NESTING
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_stall,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       verdict_valid,
  input  logic       verdict_stall,
  output logic [2:0] verdict
);

  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;

  // Input register.
  logic       s1_valid;
  logic [7:0] s1_byte;
  logic       s1_last;
  logic       s1_go;

  // Scan state.
  logic                   in_comment, in_comment_next;
  logic                   in_string, in_string_next;
  logic                   after_escape, after_escape_next;
  logic [3:0]             hdr_pos, hdr_pos_next;
  logic                   hdr_bad, hdr_bad_next;
  verdict_t               scan_err, scan_err_next;
  logic [8*(WIN_LEN-1)-1:0] recent;
  logic [KW_COUNT-1:0]    kw_seen, kw_seen_next;
  logic [KW_COUNT-1:0]    kw_hits;

  stk_cmd_t    stk_cmd;
  stk_status_t stk_status;
  logic        empty_after;
  verdict_t    verdict_next;

  assign s1_go      = s1_valid && (!s1_last || !verdict_valid || !verdict_stall);
  assign byte_stall = s1_valid && !s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (byte_valid && !byte_stall) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && !byte_stall) begin
      s1_byte <= data_byte;
      s1_last <= last_byte;
    end
  end

  vdv_kw_match u_kw (
    .win  ({recent, s1_byte}),
    .hits (kw_hits)
  );

  vdv_stack #(.MAX_NESTING(MAX_NESTING)) u_stack (
    .clk    (clk),
    .rst    (rst),
    .cmd    (stk_cmd),
    .status (stk_status)
  );

  always_comb begin
    hdr_bad_next = hdr_bad || (s1_byte == 8'h00);
    hdr_pos_next = hdr_pos;
    if (int'(hdr_pos) < HDR_LEN) begin
      hdr_bad_next = hdr_bad_next || (s1_byte != hdr_byte(hdr_pos));
      hdr_pos_next = hdr_pos + 4'd1;
    end
    kw_seen_next = kw_seen | kw_hits;

    in_comment_next   = in_comment;
    in_string_next    = in_string;
    after_escape_next = after_escape;
    scan_err_next     = scan_err;
    stk_cmd.push      = 1'b0;
    stk_cmd.pop       = 1'b0;
    stk_cmd.bracket   = (s1_byte == CH_LBRACK);
    stk_cmd.clear     = s1_go && s1_last;

    if (scan_err == VERDICT_OK) begin
      if (in_comment) begin
        in_comment_next = (s1_byte != CH_LF);
      end else if (in_string) begin
        if (after_escape) begin
          after_escape_next = 1'b0;
        end else if (s1_byte == CH_BSLASH) begin
          after_escape_next = 1'b1;
        end else if (s1_byte == CH_QUOTE) begin
          in_string_next = 1'b0;
        end
      end else begin
        case (s1_byte)
          CH_HASH: begin
            in_comment_next = 1'b1;
          end
          CH_QUOTE: begin
            in_string_next = 1'b1;
          end
          CH_LBRACE, CH_LBRACK: begin
            if (stk_status.full) begin
              scan_err_next = VERDICT_DEPTH;
            end else begin
              stk_cmd.push = s1_go;
            end
          end
          CH_RBRACE, CH_RBRACK: begin
            if (stk_status.empty ||
                (stk_status.top_bracket != (s1_byte == CH_RBRACK))) begin
              scan_err_next = VERDICT_MISMATCH;
            end else begin
              stk_cmd.pop = s1_go;
            end
          end
          default: begin
            if (s1_byte inside {[8'd0:8'd8], [8'd14:8'd31], 8'd127}) begin
              scan_err_next = VERDICT_CONTROL;
            end
          end
        endcase
      end
    end

    if (stk_cmd.push) begin
      empty_after = 1'b0;
    end else if (stk_cmd.pop) begin
      empty_after = stk_status.one_left;
    end else begin
      empty_after = stk_status.empty;
    end

    if (hdr_bad_next || (int'(hdr_pos_next) < HDR_LEN)) begin
      verdict_next = VERDICT_HEADER;
    end else if (scan_err_next != VERDICT_OK) begin
      verdict_next = scan_err_next;
    end else if (in_string_next || !empty_after ||
                 ((kw_seen_next & KW_REQUIRED) != KW_REQUIRED) ||
                 ((kw_seen_next & KW_FORBIDDEN) != '0)) begin
      verdict_next = VERDICT_FINAL;
    end else begin
      verdict_next = VERDICT_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (s1_go && s1_last)) begin
      in_comment   <= 1'b1;
      in_string    <= 1'b0;
      after_escape <= 1'b0;
      hdr_pos      <= '0;
      hdr_bad      <= 1'b0;
      scan_err     <= VERDICT_OK;
      recent       <= '0;
      kw_seen      <= '0;
    end else if (s1_go) begin
      in_comment   <= in_comment_next;
      in_string    <= in_string_next;
      after_escape <= after_escape_next;
      hdr_pos      <= hdr_pos_next;
      hdr_bad      <= hdr_bad_next;
      scan_err     <= scan_err_next;
      recent       <= {recent[8*(WIN_LEN-2)-1:0], s1_byte};
      kw_seen      <= kw_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      verdict_valid <= 1'b0;
    end else if (s1_go && s1_last) begin
      verdict_valid <= 1'b1;
    end else if (!verdict_stall) begin
      verdict_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_last) begin
      verdict <= verdict_next;
    end
  end

endmodule

// ----- hw/rtl/vdv_checker.sv -----
// ----------------------------------------------------------------------------
// vdv_checker
// Port-level checks for the VRML delimiter validator, bound to the top level.
// ----------------------------------------------------------------------------
module vdv_checker import vdv_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       byte_valid,
  input logic       byte_stall,
  input logic [7:0] data_byte,
  input logic       last_byte,
  input logic       verdict_valid,
  input logic       verdict_stall,
  input logic [2:0] verdict
);

  // A stalled verdict stays in place until its transfer.
  a_verdict_hold: assert property (@(posedge clk) disable iff (rst)
    verdict_valid && verdict_stall |=> verdict_valid && $stable(verdict))
    else $error("verdict changed while stalled");

  // Only the defined verdict codes appear.
  a_verdict_code: assert property (@(posedge clk) disable iff (rst)
    verdict_valid |-> (verdict <= VERDICT_FINAL))
    else $error("verdict code out of range");

  // The byte side stalls only while a finished verdict waits to be taken.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    byte_stall |-> verdict_valid && verdict_stall)
    else $error("byte stall without a waiting verdict");

  // Once the waiting verdict is taken, the byte side is free again.
  a_stall_release: assert property (@(posedge clk) disable iff (rst)
    !verdict_valid |-> !byte_stall)
    else $error("byte stall with the output register empty");

endmodule

bind vrml_delimiter_validator_top vdv_checker u_vdv_checker (.*);
